>>> sv/midpoint_circle_rasterizer_unit_defines.svh
// Assertion macros shared by the circle rasterizer RTL.
// Define NO_ASSERTIONS to compile the assertions out.
`ifndef MIDPOINT_CIRCLE_RASTERIZER_UNIT_DEFINES_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define MCR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define MCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define MCR_ASSERT_IMPL(label, clk, rst, ante, cons, msg)

`define MCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> sv/mcr_pkg.sv
// Shared types, constants and the point mirroring function of the circle rasterizer.
// No dependencies.
package mcr_pkg;

   localparam int COORD_BITS = 10;
   localparam int PT_BITS    = COORD_BITS + 2;
   localparam int DEC_BITS   = COORD_BITS + 3;
   localparam int OCT_BITS   = 3;
   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

   typedef logic        [COORD_BITS-1:0] coord_type;
   typedef logic signed [PT_BITS-1:0]    pt_type;
   typedef logic signed [DEC_BITS-1:0]   dec_type;
   typedef logic        [OCT_BITS-1:0]   oct_type;
   typedef logic        [Q_PTR_BITS-1:0] qptr_type;
   typedef logic        [Q_CNT_BITS-1:0] qcnt_type;

   localparam logic OP_START   = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   // 5/4 truncates to one in integer arithmetic.
   localparam dec_type DEC_INIT  = dec_type'(5 / 4);
   localparam dec_type DEC_THREE = dec_type'(3);
   localparam dec_type DEC_FIVE  = dec_type'(5);
   localparam pt_type  PT_ONE    = pt_type'(1);

   localparam oct_type OCT_XY    = 3'd0;
   localparam oct_type OCT_YX    = 3'd1;
   localparam oct_type OCT_YNX   = 3'd2;
   localparam oct_type OCT_XNY   = 3'd3;
   localparam oct_type OCT_NXNY  = 3'd4;
   localparam oct_type OCT_NYNX  = 3'd5;
   localparam oct_type OCT_NYX   = 3'd6;
   localparam oct_type OCT_NXY   = 3'd7;
   localparam oct_type OCT_FIRST = OCT_XY;
   localparam oct_type OCT_LAST  = OCT_NXY;

   localparam qptr_type QPTR_ZERO = qptr_type'(0);
   localparam qptr_type QPTR_ONE  = qptr_type'(1);
   localparam qptr_type QPTR_LAST = qptr_type'(Q_DEPTH - 1);
   localparam qcnt_type QCNT_ONE  = qcnt_type'(1);
   localparam qcnt_type QCNT_FULL = qcnt_type'(Q_DEPTH);

   // One step of a circle: the offsets whose eight mirrors are emitted.
   typedef struct packed {
      coord_type center_x;
      coord_type center_y;
      coord_type x;
      coord_type y;
      logic      done;
   } step_type;

   typedef struct packed {
      pt_type px;
      pt_type py;
   } point_type;

   function automatic point_type point_of(step_type s, oct_type k);
      point_type r;
      pt_type    cx;
      pt_type    cy;
      pt_type    ox;
      pt_type    oy;
      cx = pt_type'(s.center_x);
      cy = pt_type'(s.center_y);
      ox = pt_type'(s.x);
      oy = pt_type'(s.y);
      case (k)
         OCT_XY:   begin r.px = cx + ox; r.py = cy + oy; end
         OCT_YX:   begin r.px = cx + oy; r.py = cy + ox; end
         OCT_YNX:  begin r.px = cx + oy; r.py = cy - ox; end
         OCT_XNY:  begin r.px = cx + ox; r.py = cy - oy; end
         OCT_NXNY: begin r.px = cx - ox; r.py = cy - oy; end
         OCT_NYNX: begin r.px = cx - oy; r.py = cy - ox; end
         OCT_NYX:  begin r.px = cx - oy; r.py = cy + ox; end
         OCT_NXY:  begin r.px = cx - ox; r.py = cy + oy; end
         default:  begin r.px = cx;      r.py = cy;      end
      endcase
      return r;
   endfunction

endpackage

>>> sv/mcr_channels.sv
// Request and response channel interfaces of the circle rasterizer.
// Depends on mcr_pkg for the payload types.
interface mcr_req_if;
   logic                 valid;
   logic                 ready;
   logic                 op;
   mcr_pkg::coord_type   center_x;
   mcr_pkg::coord_type   center_y;
   mcr_pkg::coord_type   radius;

   modport source (output valid, op, center_x, center_y, radius, input ready);
   modport sink   (input valid, op, center_x, center_y, radius, output ready);
endinterface

interface mcr_rsp_if;
   logic                 valid;
   logic                 ready;
   mcr_pkg::pt_type      point_x;
   mcr_pkg::pt_type      point_y;
   mcr_pkg::oct_type     octant;
   logic                 last_of_step;
   logic                 circle_done;

   modport source (output valid, point_x, point_y, octant, last_of_step, circle_done,
                   input ready);
   modport sink   (input valid, point_x, point_y, octant, last_of_step, circle_done,
                   output ready);
endinterface

>>> sv/midpoint_circle_rasterizer_unit.sv
// Midpoint circle rasterizer top level: front part, step queue and back part.
// A request's step goes through the step queue, then the registered response stage.
// Throughput: one step of eight points, bounded by the response channel carrying one
// point per cycle while the receiver is ready; requests are taken every cycle while
// the two-entry step queue has room. Synchronous reset clears the circle state, the
// decision, the active flag, the queue and the response valid.
module midpoint_circle_rasterizer_unit (
   input  logic      clock,
   input  logic      reset,
   mcr_req_if.sink   req_ch,
   mcr_rsp_if.source rsp_ch
);

   logic              q_push;
   logic              q_ready;
   logic              q_pop;
   logic              q_valid;
   mcr_pkg::step_type q_step;
   mcr_pkg::step_type q_head;

   mcr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .q_ready (q_ready),
      .q_push  (q_push),
      .q_step  (q_step)
   );

   mcr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_step (q_step),
      .ready     (q_ready),
      .pop       (q_pop),
      .valid     (q_valid),
      .head      (q_head)
   );

   mcr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

>>> sv/mcr_queue.sv
// Small step queue between the front and back parts of the circle rasterizer.
// Depends on mcr_pkg and the assertion macro header.
`include "midpoint_circle_rasterizer_unit_defines.svh"

module mcr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mcr_pkg::step_type  push_step,
   output logic               ready,
   input  logic               pop,
   output logic               valid,
   output mcr_pkg::step_type  head
);

   mcr_pkg::step_type slot_ff [mcr_pkg::Q_DEPTH];
   mcr_pkg::qptr_type wr_ptr_ff, wr_ptr_in;
   mcr_pkg::qptr_type rd_ptr_ff, rd_ptr_in;
   mcr_pkg::qcnt_type count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mcr_pkg::QPTR_LAST) ? mcr_pkg::QPTR_ZERO
                                                       : wr_ptr_ff + mcr_pkg::QPTR_ONE;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == mcr_pkg::QPTR_LAST) ? mcr_pkg::QPTR_ZERO
                                                       : rd_ptr_ff + mcr_pkg::QPTR_ONE;
      end
      if (push && !pop) begin
         count_in = count_ff + mcr_pkg::QCNT_ONE;
      end else if (pop && !push) begin
         count_in = count_ff - mcr_pkg::QCNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= mcr_pkg::QPTR_ZERO;
         rd_ptr_ff <= mcr_pkg::QPTR_ZERO;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_step;
      end
   end

   assign ready = (count_ff != mcr_pkg::QCNT_FULL);
   assign valid = (count_ff != '0);
   assign head  = slot_ff[rd_ptr_ff];

   `MCR_ASSERT_IMPL(a_no_push_when_full, clock, reset, push, count_ff < mcr_pkg::QCNT_FULL, "step queue overflow")
   `MCR_ASSERT_IMPL(a_no_pop_when_empty, clock, reset, pop, count_ff != '0, "step queue underflow")

endmodule

>>> sv/mcr_front.sv
// Front part of the circle rasterizer: takes requests, keeps the circle state
// and the decision variable, and queues one step record per emitting request.
// Depends on mcr_pkg, the channel interfaces and the assertion macro header.
`include "midpoint_circle_rasterizer_unit_defines.svh"

module mcr_front (
   input  logic               clock,
   input  logic               reset,
   mcr_req_if.sink            req_ch,
   input  logic               q_ready,
   output logic               q_push,
   output mcr_pkg::step_type  q_step
);

   mcr_pkg::coord_type cx_ff, cx_in;
   mcr_pkg::coord_type cy_ff, cy_in;
   mcr_pkg::coord_type x_ff, x_in;
   mcr_pkg::coord_type y_ff, y_in;
   mcr_pkg::dec_type   p_ff, p_in;
   logic               active_ff, active_in;

   logic               accept;
   logic               load;
   logic               act;
   logic               past_end;
   mcr_pkg::coord_type ax, ay;
   mcr_pkg::dec_type   ap, xe, ye, pn;
   mcr_pkg::coord_type xn, yn;
   logic               done;

   always_comb begin
      accept = req_ch.valid && req_ch.ready;
      load   = (req_ch.op == mcr_pkg::OP_START);
      act    = load || active_ff;
      cx_in  = load ? req_ch.center_x : cx_ff;
      cy_in  = load ? req_ch.center_y : cy_ff;
      ax     = load ? '0 : x_ff;
      ay     = load ? req_ch.radius : y_ff;
      ap     = load ? mcr_pkg::DEC_INIT - mcr_pkg::dec_type'(req_ch.radius) : p_ff;
      past_end = (ax > ay);

      xe = mcr_pkg::dec_type'(ax);
      ye = mcr_pkg::dec_type'(ay);
      xn = ax + mcr_pkg::coord_type'(1);
      // Negative decision keeps y; otherwise y steps inward.
      if (ap[mcr_pkg::DEC_BITS-1]) begin
         pn   = ap + (xe <<< 1) + mcr_pkg::DEC_THREE;
         yn   = ay;
         done = (mcr_pkg::pt_type'(ax) + mcr_pkg::PT_ONE) > mcr_pkg::pt_type'(ay);
      end else begin
         pn   = ap + ((xe - ye) <<< 1) + mcr_pkg::DEC_FIVE;
         yn   = ay - mcr_pkg::coord_type'(1);
         done = (mcr_pkg::pt_type'(ax) + mcr_pkg::PT_ONE) >
                (mcr_pkg::pt_type'(ay) - mcr_pkg::PT_ONE);
      end

      x_in      = x_ff;
      y_in      = y_ff;
      p_in      = p_ff;
      active_in = active_ff;
      if (act) begin
         if (past_end) begin
            active_in = 1'b0;
         end else begin
            x_in      = xn;
            y_in      = yn;
            p_in      = pn;
            active_in = !done;
         end
      end

      q_push          = accept && act && !past_end;
      q_step.center_x = cx_in;
      q_step.center_y = cy_in;
      q_step.x        = ax;
      q_step.y        = ay;
      q_step.done     = done;
   end

   assign req_ch.ready = q_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff     <= '0;
         cy_ff     <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
         p_ff      <= '0;
         active_ff <= 1'b0;
      end else if (accept && act) begin
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         p_ff      <= p_in;
         active_ff <= active_in;
      end
   end

   `MCR_ASSERT_IMPL(a_active_inside_octant, clock, reset, active_ff, x_ff <= y_ff, "active circle has x beyond y")
   `MCR_ASSERT_NEXT(a_done_ends_circle, clock, reset, q_push && q_step.done, !active_ff, "circle still active after its last step")

endmodule

>>> sv/mcr_back.sv
// Back part of the circle rasterizer: expands each queued step into its eight
// mirrored points, one per cycle unless stalled, via a registered response stage.
// Depends on mcr_pkg, the channel interfaces and the assertion macro header.
`include "midpoint_circle_rasterizer_unit_defines.svh"

module mcr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  mcr_pkg::step_type  q_head,
   output logic               q_pop,
   mcr_rsp_if.source          rsp_ch
);

   mcr_pkg::step_type  rec_ff, rec_in;
   mcr_pkg::oct_type   oct_ff, oct_in;
   logic               valid_ff, valid_in;
   mcr_pkg::point_type pt_ff, pt_in;

   logic               take;
   logic               last;

   always_comb begin
      take     = valid_ff && rsp_ch.ready;
      last     = (oct_ff == mcr_pkg::OCT_LAST);
      // A new step enters when the stage is empty or its final point leaves now.
      q_pop    = q_valid && (!valid_ff || (take && last));
      rec_in   = rec_ff;
      oct_in   = oct_ff;
      valid_in = valid_ff;
      pt_in    = pt_ff;
      if (q_pop) begin
         rec_in   = q_head;
         oct_in   = mcr_pkg::OCT_FIRST;
         valid_in = 1'b1;
         pt_in    = mcr_pkg::point_of(q_head, mcr_pkg::OCT_FIRST);
      end else if (take && !last) begin
         oct_in = oct_ff + mcr_pkg::oct_type'(1);
         pt_in  = mcr_pkg::point_of(rec_ff, oct_ff + mcr_pkg::oct_type'(1));
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         oct_ff   <= mcr_pkg::OCT_FIRST;
      end else begin
         valid_ff <= valid_in;
         oct_ff   <= oct_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      pt_ff  <= pt_in;
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.point_x      = pt_ff.px;
   assign rsp_ch.point_y      = pt_ff.py;
   assign rsp_ch.octant       = oct_ff;
   assign rsp_ch.last_of_step = last;
   assign rsp_ch.circle_done  = last && rec_ff.done;

   `MCR_ASSERT_NEXT(a_idle_stage_loads, clock, reset, q_valid && !valid_ff, valid_ff && (oct_ff == mcr_pkg::OCT_FIRST), "waiting step not loaded into idle stage")
   `MCR_ASSERT_NEXT(a_octant_advances, clock, reset, take && !last, valid_ff && (oct_ff == $past(oct_ff) + mcr_pkg::oct_type'(1)), "octant did not advance after a taken point")

endmodule

>>> tb/sv/midpoint_circle_rasterizer_unit_test.sv
// Self-checking testbench of the midpoint circle rasterizer: random bursts of requests,
// a stalling receiver and a predictor that checks every emitted point.
// Depends on mcr_pkg, mcr_channels and midpoint_circle_rasterizer_unit.
module midpoint_circle_rasterizer_unit_test;
   import mcr_pkg::*;

   typedef struct {
      logic      op;
      coord_type center_x;
      coord_type center_y;
      coord_type radius;
      bit        drain_first;
   } circle_request_t;

   typedef struct {
      pt_type  px;
      pt_type  py;
      oct_type octant;
      logic    last_of_step;
      logic    circle_done;
   } circle_point_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic      req_valid    = 1'b0;
   logic      req_op       = OP_ADVANCE;
   coord_type req_center_x = '0;
   coord_type req_center_y = '0;
   coord_type req_radius   = '0;
   logic      rsp_ready    = 1'b0;

   mcr_req_if req_ch ();
   mcr_rsp_if rsp_ch ();

   assign req_ch.valid    = req_valid;
   assign req_ch.op       = req_op;
   assign req_ch.center_x = req_center_x;
   assign req_ch.center_y = req_center_y;
   assign req_ch.radius   = req_radius;
   assign rsp_ch.ready    = rsp_ready;

   midpoint_circle_rasterizer_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   circle_request_t pending_requests[$];
   circle_point_t   expected_points[$];
   circle_request_t cur_request;

   // Predicted circle state.
   coord_type circ_cx     = '0;
   coord_type circ_cy     = '0;
   coord_type circ_off_x  = '0;
   coord_type circ_off_y  = '0;
   dec_type   circ_dec    = '0;
   bit        circ_active = 1'b0;

   int points_predicted = 0;
   int points_received  = 0;
   int mismatch_count   = 0;

   int burst_left = 1;
   int gap_left   = 0;
   int rx_mode    = 0;
   int rx_left    = 0;
   int rx_phase   = 0;

   task automatic rasterize_request(input circle_request_t rq);
      int            cx;
      int            cy;
      int            x;
      int            y;
      int            p;
      int            ny;
      int            vx;
      int            vy;
      bit            finished;
      oct_type       oc;
      circle_point_t pt;
      if (rq.op == OP_START) begin
         circ_cx     = rq.center_x;
         circ_cy     = rq.center_y;
         circ_off_x  = '0;
         circ_off_y  = rq.radius;
         circ_dec    = dec_type'(int'(DEC_INIT) - int'(rq.radius));
         circ_active = 1'b1;
      end
      if (!circ_active) return;
      cx = circ_cx;
      cy = circ_cy;
      x  = circ_off_x;
      y  = circ_off_y;
      if (x > y) begin
         circ_active = 1'b0;
         return;
      end
      p = circ_dec;
      if (p < 0) begin
         p  = p + 2 * x + int'(DEC_THREE);
         ny = y;
      end else begin
         p  = p + 2 * (x - y) + int'(DEC_FIVE);
         ny = y - 1;
      end
      circ_dec   = dec_type'(p);
      circ_off_x = coord_type'(x + 1);
      circ_off_y = coord_type'(ny);
      // The done test uses the unwrapped new y, so y stepping below zero ends the circle.
      finished = (x + 1) > ny;
      if (finished) circ_active = 1'b0;
      for (int k = 0; k < 8; k++) begin
         oc = oct_type'(k);
         case (oc)
            OCT_XY:   begin vx = cx + x; vy = cy + y; end
            OCT_YX:   begin vx = cx + y; vy = cy + x; end
            OCT_YNX:  begin vx = cx + y; vy = cy - x; end
            OCT_XNY:  begin vx = cx + x; vy = cy - y; end
            OCT_NXNY: begin vx = cx - x; vy = cy - y; end
            OCT_NYNX: begin vx = cx - y; vy = cy - x; end
            OCT_NYX:  begin vx = cx - y; vy = cy + x; end
            default:  begin vx = cx - x; vy = cy + y; end
         endcase
         pt.px           = pt_type'(vx);
         pt.py           = pt_type'(vy);
         pt.octant       = oc;
         pt.last_of_step = (oc == OCT_LAST);
         pt.circle_done  = (oc == OCT_LAST) && finished;
         expected_points.push_back(pt);
         points_predicted++;
      end
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ch.ready) rasterize_request(cur_request);
         if (req_valid && !req_ch.ready) begin
            // Hold the request until it is taken.
         end else if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_requests.size() == 0 ||
                      (pending_requests[0].drain_first &&
                       points_predicted != points_received)) begin
            req_valid <= 1'b0;
         end else begin
            cur_request = pending_requests.pop_front();
            req_valid    <= 1'b1;
            req_op       <= cur_request.op;
            req_center_x <= cur_request.center_x;
            req_center_y <= cur_request.center_y;
            req_radius   <= cur_request.radius;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               if ($urandom_range(0, 99) < 30) gap_left = 0;
               else if ($urandom_range(0, 99) < 85) gap_left = $urandom_range(1, 8);
               else gap_left = $urandom_range(9, 30);
            end
         end
      end
   end

   // Receiver stalls: always ready, coin flip, mostly stalled, or rx_phase % 4 == 0.
   always @(posedge clock) begin
      bit rdy;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
         end
         rx_left--;
         rx_phase++;
         case (rx_mode)
            0:       rdy = 1'b1;
            1:       rdy = $urandom_range(0, 1);
            2:       rdy = ($urandom_range(0, 3) == 0);
            default: rdy = (rx_phase % 4 == 0);
         endcase
         rsp_ready <= rdy;
      end
   end

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Response monitor.
   always @(posedge clock) begin
      circle_point_t want;
      if (!reset && rsp_ch.valid && rsp_ready) begin
         points_received <= points_received + 1;
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected point, expected none, actual (%0d, %0d) octant %0d",
                     $time, rsp_ch.point_x, rsp_ch.point_y, rsp_ch.octant);
            mismatch_count++;
         end else begin
            want = expected_points.pop_front();
            compare_field("point_x", int'(want.px), int'(rsp_ch.point_x));
            compare_field("point_y", int'(want.py), int'(rsp_ch.point_y));
            compare_field("octant", int'(want.octant), int'(rsp_ch.octant));
            compare_field("last_of_step", int'(want.last_of_step),
                          int'(rsp_ch.last_of_step));
            compare_field("circle_done", int'(want.circle_done),
                          int'(rsp_ch.circle_done));
         end
      end
   end

   task automatic add_request(input logic op, input int cx, input int cy, input int r,
                              input bit drain);
      circle_request_t rq;
      rq.op          = op;
      rq.center_x    = coord_type'(cx);
      rq.center_y    = coord_type'(cy);
      rq.radius      = coord_type'(r);
      rq.drain_first = drain;
      pending_requests.push_back(rq);
   endtask

   task automatic add_advances(input int n);
      for (int i = 0; i < n; i++)
         add_request(OP_ADVANCE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                     $urandom_range(0, 1023), 1'b0);
   endtask

   function automatic int random_coord();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 0;
      if (sel == 1) return 1023;
      return $urandom_range(0, 1023);
   endfunction

   initial begin
      int queued;
      int sel;
      int r;
      int n;
      // Directed part.
      add_advances(1);                               // advance with no circle
      add_request(OP_START, 0, 0, 0, 1'b0);          // zero radius
      add_advances(1);
      add_request(OP_START, 1023, 1023, 1023, 1'b0);
      add_advances(2);
      add_request(OP_START, 0, 0, 1023, 1'b0);       // start while a circle runs
      add_advances(2);
      add_request(OP_START, 512, 300, 1, 1'b0);
      add_advances(2);
      add_request(OP_START, 1023, 0, 5, 1'b1);       // waits for the pipe to empty
      add_advances(5);
      add_request(OP_START, 0, 1023, 2, 1'b0);
      add_advances(2);

      // Random part: mostly complete circles, some cut short, some stray advances.
      queued = 0;
      while (queued < 400) begin
         sel = $urandom_range(0, 99);
         if (sel < 8) begin
            n = $urandom_range(1, 3);
            add_advances(n);
            queued += n;
         end else begin
            sel = $urandom_range(0, 99);
            if (sel < 60) r = $urandom_range(0, 15);
            else if (sel < 85) r = $urandom_range(16, 63);
            else r = $urandom_range(0, 1023);
            add_request(OP_START, random_coord(), random_coord(), r,
                        $urandom_range(0, 99) < 3);
            if (r <= 63 && $urandom_range(0, 99) < 80) n = r * 3 / 4 + 1 + $urandom_range(0, 2);
            else n = $urandom_range(0, (r < 20) ? r : 20);
            add_advances(n);
            queued += n + 1;
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (expected_points.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (expected_points.size() != 0) begin
         $display("%0t: %0d points never arrived", $time, expected_points.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
